@@ rtl/core/gesture_binding_table_defines.svh @@
// Assertion macros shared by the gesture binding table RTL.
`ifndef GESTURE_BINDING_TABLE_DEFINES_SVH
`define GESTURE_BINDING_TABLE_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define GBT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gesture binding table assertion failed");

// Checks a property at every rising clock edge, reset included.
`define GBT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("gesture binding table assertion failed");

`endif

@@ rtl/core/gbt_pkg.sv @@
package gbt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_LOOKUP   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_FULL     = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_SCAN    = 3'd1,
    S_ADJUST  = 3'd2,
    S_WRITE   = 3'd3,
    S_REM_RD  = 3'd4,
    S_REM_CAP = 3'd5,
    S_DONE    = 3'd6
  } state_e;

  localparam logic [1:0] GT_NONE  = 2'd0;
  localparam logic [1:0] GT_PINCH = 2'd2;
  localparam logic [1:0] GT_SWIPE = 2'd3;

  localparam logic [1:0] DEV_TOUCHPAD = 2'b01;

  localparam logic [7:0] DIR_UP    = 8'h01;
  localparam logic [7:0] DIR_DOWN  = 8'h02;
  localparam logic [7:0] DIR_LEFT  = 8'h04;
  localparam logic [7:0] DIR_RIGHT = 8'h08;

  localparam logic [3:0] EDGE_TOP    = 4'h1;
  localparam logic [3:0] EDGE_BOTTOM = 4'h2;
  localparam logic [3:0] EDGE_LEFT   = 4'h4;
  localparam logic [3:0] EDGE_RIGHT  = 4'h8;

  localparam logic [3:0] MIN_PINCH_FINGERS = 4'd2;
  localparam logic [3:0] ONE_FINGER        = 4'd1;

  typedef struct packed {
    logic [3:0] fingers;
    logic [3:0] edges;
    logic [7:0] dirs;
    logic [1:0] devs;
    logic [1:0] gtype;
  } pattern_t;

  function automatic logic pattern_ok(pattern_t p);
    logic ok;
    logic has_edge;
    logic has_pad;
    ok       = 1'b1;
    has_edge = (p.edges != 4'd0);
    has_pad  = ((p.devs & DEV_TOUCHPAD) != 2'd0);
    if (p.gtype == GT_NONE || p.devs == 2'd0 || p.fingers == 4'd0) begin
      ok = 1'b0;
    end
    if (p.gtype == GT_PINCH && p.fingers < MIN_PINCH_FINGERS) begin
      ok = 1'b0;
    end
    if ((p.gtype == GT_PINCH || has_pad) && has_edge) begin
      ok = 1'b0;
    end
    if (p.gtype == GT_SWIPE && p.fingers == ONE_FINGER && (has_pad || !has_edge)) begin
      ok = 1'b0;
    end
    // A directional edge swipe must start from the opposite edge.
    if (has_edge &&
        ((((p.dirs & DIR_LEFT) != 8'd0) && ((p.edges & EDGE_RIGHT) == 4'd0)) ||
         (((p.dirs & DIR_RIGHT) != 8'd0) && ((p.edges & EDGE_LEFT) == 4'd0)) ||
         (((p.dirs & DIR_UP) != 8'd0) && ((p.edges & EDGE_BOTTOM) == 4'd0)) ||
         (((p.dirs & DIR_DOWN) != 8'd0) && ((p.edges & EDGE_TOP) == 4'd0)))) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Stored zero direction or edge masks act as wildcards.
  function automatic logic entry_hits(pattern_t e, pattern_t q);
    return (e.gtype == q.gtype) && (e.fingers == q.fingers) &&
           ((e.devs & q.devs) != 2'd0) &&
           (e.dirs == 8'd0 || (e.dirs & q.dirs) != 8'd0) &&
           (e.edges == 4'd0 || (e.edges & q.edges) != 4'd0);
  endfunction

endpackage

@@ rtl/core/gbt_if.sv @@
interface gbt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] gesture_kind;
  logic [1:0] device_mask;
  logic [7:0] direction_mask;
  logic [3:0] edge_mask;
  logic [3:0] finger_count;
  logic [3:0] slot_index;

  modport source (
    output valid, action, gesture_kind, device_mask, direction_mask, edge_mask,
           finger_count, slot_index,
    input  ready
  );
  modport sink (
    input  valid, action, gesture_kind, device_mask, direction_mask, edge_mask,
           finger_count, slot_index,
    output ready
  );
endinterface

interface gbt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] slot_found;

  modport source (
    output valid, status, slot_found,
    input  ready
  );
  modport sink (
    input  valid, status, slot_found,
    output ready
  );
endinterface

@@ rtl/core/gesture_binding_table.sv @@
// Gesture binding table: one item in, one result item out, one item at a time. The table
// lives in a single-port-read, single-port-write memory that a small sequencer walks one
// entry per cycle through a shared compare and rank-adjust unit. Counted from the accepting
// edge to the edge that loads the result register, with N entries, an invalid pattern, an
// unused action or a remove of a free slot takes 1 cycle; a lookup or a rejected register
// takes N+3 (19 at N=16); a remove takes N+5; a successful register takes 2N+6 (38 at
// N=16), since it walks the table once to check conflicts and once to age the stored
// entries. The input is ready again in the cycle after the result is loaded into the output
// register, so each item occupies one cycle more than these figures, and the next item may
// be taken while that result waits. A result that is still waiting when the next one is
// done holds the block until it is taken. Slot numbers above fifteen are reported by their
// low four bits.
`include "gesture_binding_table_defines.svh"

module gesture_binding_table #(
  parameter int TABLE_ENTRIES = gbt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  gbt_in_if.sink    in_i,
  gbt_out_if.source out_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int SXW   = (IDX_W > 4) ? IDX_W : 4;
  localparam int PAT_W = $bits(gbt_pkg::pattern_t);
  localparam int MEM_W = IDX_W + PAT_W;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  gbt_pkg::state_e state_q, state_d;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]         rd_idx_q, rd_idx_d;
  logic                     clash_q, clash_d;
  logic                     free_found_q, free_found_d;
  logic                     hit_q, hit_d;
  logic                     out_vld_q, out_vld_d;

  gbt_pkg::action_e   op_q, op_d;
  gbt_pkg::pattern_t  req_q, req_d;
  logic [IDX_W-1:0]   sidx_q, sidx_d;
  logic [IDX_W-1:0]   free_slot_q, free_slot_d;
  logic [IDX_W-1:0]   best_slot_q, best_slot_d;
  logic [IDX_W-1:0]   best_rank_q, best_rank_d;
  logic [IDX_W-1:0]   rem_rank_q, rem_rank_d;
  gbt_pkg::status_e   res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_slot_q, res_slot_d;
  logic [2:0]         out_status_q, out_status_d;
  logic [3:0]         out_slot_q, out_slot_d;

  logic [MEM_W-1:0] entry_mem [TABLE_ENTRIES];
  logic [MEM_W-1:0] rd_data_q;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  gbt_pkg::pattern_t in_pat;
  gbt_pkg::pattern_t rd_pat;
  logic [IDX_W-1:0]  rd_rank;
  logic [SXW-1:0]    in_sidx_w;
  logic              in_sidx_ok;
  logic              accept;
  logic              issue_more;
  logic              walk_done;
  logic              rd_entry_valid;
  logic              rd_hits;
  logic              out_free;

  assign in_pat.gtype   = in_i.gesture_kind;
  assign in_pat.devs    = in_i.device_mask;
  assign in_pat.dirs    = in_i.direction_mask;
  assign in_pat.edges   = in_i.edge_mask;
  assign in_pat.fingers = in_i.finger_count;

  assign in_sidx_w  = SXW'(in_i.slot_index);
  assign in_sidx_ok = (32'(in_i.slot_index) < TABLE_ENTRIES) &&
                      valid_q[in_sidx_w[IDX_W-1:0]];

  assign in_i.ready = (state_q == gbt_pkg::S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign rd_pat         = gbt_pkg::pattern_t'(rd_data_q[PAT_W-1:0]);
  assign rd_rank        = rd_data_q[MEM_W-1:PAT_W];
  assign rd_entry_valid = valid_q[rd_idx_q];
  assign rd_hits        = gbt_pkg::entry_hits(rd_pat, req_q);
  assign issue_more     = (cnt_q < CNT_END);
  assign walk_done      = !issue_more && !rd_vld_q;
  assign out_free       = !out_vld_q || out_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbt_pkg::S_IDLE: begin
        if (accept) begin
          case (in_i.action)
            gbt_pkg::ACT_REGISTER: begin
              state_d = gbt_pkg::pattern_ok(in_pat) ? gbt_pkg::S_SCAN : gbt_pkg::S_DONE;
            end
            gbt_pkg::ACT_REMOVE: begin
              state_d = in_sidx_ok ? gbt_pkg::S_REM_RD : gbt_pkg::S_DONE;
            end
            gbt_pkg::ACT_LOOKUP: state_d = gbt_pkg::S_SCAN;
            default:             state_d = gbt_pkg::S_DONE;
          endcase
        end
      end
      gbt_pkg::S_SCAN: begin
        if (walk_done) begin
          if (op_q == gbt_pkg::ACT_REGISTER && !clash_q && free_found_q) begin
            state_d = gbt_pkg::S_ADJUST;
          end else begin
            state_d = gbt_pkg::S_DONE;
          end
        end
      end
      gbt_pkg::S_ADJUST: begin
        if (walk_done) begin
          state_d = (op_q == gbt_pkg::ACT_REGISTER) ? gbt_pkg::S_WRITE : gbt_pkg::S_DONE;
        end
      end
      gbt_pkg::S_WRITE:   state_d = gbt_pkg::S_DONE;
      gbt_pkg::S_REM_RD:  state_d = gbt_pkg::S_REM_CAP;
      gbt_pkg::S_REM_CAP: state_d = gbt_pkg::S_ADJUST;
      gbt_pkg::S_DONE: begin
        if (out_free) begin
          state_d = gbt_pkg::S_IDLE;
        end
      end
      default: state_d = gbt_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    clash_d      = clash_q;
    free_found_d = free_found_q;
    hit_d        = hit_q;
    op_d         = op_q;
    req_d        = req_q;
    sidx_d       = sidx_q;
    free_slot_d  = free_slot_q;
    best_slot_d  = best_slot_q;
    best_rank_d  = best_rank_q;
    rem_rank_d   = rem_rank_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    mem_re       = 1'b0;
    mem_raddr    = cnt_q[IDX_W-1:0];
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = rd_data_q;

    // Both table walks issue one read per cycle; the read data is registered.
    if ((state_q == gbt_pkg::S_SCAN || state_q == gbt_pkg::S_ADJUST) && issue_more) begin
      mem_re   = 1'b1;
      rd_vld_d = 1'b1;
      rd_idx_d = cnt_q[IDX_W-1:0];
      cnt_d    = cnt_q + CNT_W'(1);
    end

    case (state_q)
      gbt_pkg::S_IDLE: begin
        if (accept) begin
          op_d         = gbt_pkg::action_e'(in_i.action);
          req_d        = in_pat;
          sidx_d       = in_sidx_w[IDX_W-1:0];
          cnt_d        = '0;
          clash_d      = 1'b0;
          free_found_d = 1'b0;
          hit_d        = 1'b0;
          res_slot_d   = '0;
          case (in_i.action)
            gbt_pkg::ACT_REGISTER: res_status_d = gbt_pkg::ST_INVALID;
            gbt_pkg::ACT_REMOVE:   res_status_d = gbt_pkg::ST_EMPTY;
            default:               res_status_d = gbt_pkg::ST_MISS;
          endcase
        end
      end
      gbt_pkg::S_SCAN: begin
        if (rd_vld_q) begin
          if (op_q == gbt_pkg::ACT_REGISTER) begin
            if (rd_entry_valid && rd_hits) begin
              clash_d = 1'b1;
            end
            if (!rd_entry_valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_slot_d  = rd_idx_q;
            end
          end else if (rd_entry_valid && rd_hits && (!hit_q || rd_rank < best_rank_q)) begin
            hit_d       = 1'b1;
            best_slot_d = rd_idx_q;
            best_rank_d = rd_rank;
          end
        end
        if (walk_done) begin
          cnt_d = '0;
          if (op_q == gbt_pkg::ACT_REGISTER) begin
            if (clash_q) begin
              res_status_d = gbt_pkg::ST_CONFLICT;
            end else if (!free_found_q) begin
              res_status_d = gbt_pkg::ST_FULL;
            end
          end else if (hit_q) begin
            res_status_d = gbt_pkg::ST_OK;
            res_slot_d   = best_slot_q;
          end
        end
      end
      gbt_pkg::S_ADJUST: begin
        // Register ages every stored entry; remove closes the gap left in the ranks.
        if (rd_vld_q && rd_entry_valid) begin
          if (op_q == gbt_pkg::ACT_REGISTER) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_rank + IDX_W'(1), rd_data_q[PAT_W-1:0]};
          end else if (rd_rank > rem_rank_q) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_rank - IDX_W'(1), rd_data_q[PAT_W-1:0]};
          end
        end
        if (walk_done && op_q == gbt_pkg::ACT_REMOVE) begin
          res_status_d = gbt_pkg::ST_OK;
        end
      end
      gbt_pkg::S_WRITE: begin
        mem_we               = 1'b1;
        mem_waddr            = free_slot_q;
        mem_wdata            = {IDX_W'(0), req_q};
        valid_d[free_slot_q] = 1'b1;
        res_status_d         = gbt_pkg::ST_OK;
        res_slot_d           = free_slot_q;
      end
      gbt_pkg::S_REM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sidx_q;
      end
      gbt_pkg::S_REM_CAP: begin
        rem_rank_d      = rd_rank;
        valid_d[sidx_q] = 1'b0;
        cnt_d           = '0;
      end
      gbt_pkg::S_DONE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = 4'(res_slot_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gbt_pkg::S_IDLE;
      valid_q      <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      clash_q      <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      cnt_q        <= cnt_d;
      rd_vld_q     <= rd_vld_d;
      clash_q      <= clash_d;
      free_found_q <= free_found_d;
      hit_q        <= hit_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    sidx_q       <= sidx_d;
    rd_idx_q     <= rd_idx_d;
    free_slot_q  <= free_slot_d;
    best_slot_q  <= best_slot_d;
    best_rank_q  <= best_rank_d;
    rem_rank_q   <= rem_rank_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= entry_mem[mem_raddr];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_found = out_slot_q;

  `GBT_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q != gbt_pkg::S_IDLE))
  `GBT_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == gbt_pkg::S_DONE))
  `GBT_ASSERT(a_mem_write_state, clk_i, rst_ni, mem_we |-> (state_q == gbt_pkg::S_ADJUST || state_q == gbt_pkg::S_WRITE))
  `GBT_ASSERT(a_valid_set_on_write, clk_i, rst_ni, ((valid_d & ~valid_q) != '0) |-> (state_q == gbt_pkg::S_WRITE))
  `GBT_ASSERT_ALWAYS(a_cnt_in_range, clk_i, cnt_q <= CNT_END)

endmodule
